### design/false_color_palette_generator_unit_macros.svh
// assertion macros for the false-colour palette generator
// used by the top level, which supplies clk and rst in scope
`ifndef FALSE_COLOR_PALETTE_GENERATOR_UNIT_MACROS_SVH
`define FALSE_COLOR_PALETTE_GENERATOR_UNIT_MACROS_SVH

// condition holds in the same cycle
`define FCPG_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcpg check failed");

// condition holds in the next cycle
`define FCPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcpg check failed");

`endif

### design/fcpg_pkg.sv
// shared types and constants of the false-colour palette generator
// no dependencies
`default_nettype none

package fcpg_pkg;

  localparam int unsigned MAX_ENTRIES = 256;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned N_W         = 9;
  localparam int unsigned CH_W        = 16;
  localparam int unsigned TYPE_W      = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 9;

  // colour map selection
  typedef enum logic [TYPE_W-1:0] {
    MAP_RAINBOW  = 3'd0,
    MAP_PERIODIC = 3'd1,
    MAP_HOT      = 3'd2,
    MAP_COOL     = 3'd3,
    MAP_REDBLUE  = 3'd4,
    MAP_GRAY     = 3'd5,
    MAP_HELIX    = 3'd6
  } map_t;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_TYPE = 1'b0,
    REG_MAP_SIZE = 1'b1
  } cfg_reg_t;

  // which ramp of the hot map an entry sits on
  typedef enum logic [1:0] {
    HOT_RED,
    HOT_GREEN,
    HOT_BLUE
  } hot_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  localparam logic [N_W-1:0]  MAP_SIZE_RST = 9'd151;
  localparam logic [15:0]     FULL         = 16'd65280;
  localparam logic [16:0]     ONE16        = 17'h10000;

  // arc geometry in Q0.16
  localparam logic [16:0]     TH_HI        = 17'd43691;
  localparam logic [16:0]     TH_LO        = 17'd21845;
  localparam logic [16:0]     R_OFS        = 17'd21846;
  localparam logic [16:0]     G_TOP        = 17'd43691;
  localparam logic [16:0]     B_TOP        = 17'd68813;
  localparam logic [16:0]     B_LO         = 17'd21845;
  localparam logic [31:0]     K_RG         = 32'd765;
  localparam logic [31:0]     K_B          = 32'd182131;
  localparam int unsigned     SH_RG        = 15;
  localparam int unsigned     SH_B         = 23;

  // quarter-wave sine polynomial
  localparam logic [31:0]     Q_C1         = 32'd2463;
  localparam logic [15:0]     Q_C2         = 16'd21167;
  localparam logic [15:0]     Q_C3         = 16'd51472;
  localparam logic [31:0]     Q_MAX        = 32'd32767;

  // cubehelix
  localparam logic [15:0]     HX_START     = 16'd10923;
  localparam logic [15:0]     HX_QUART     = 16'h4000;
  localparam logic [31:0]     HX_AMP       = 32'd39322;
  localparam logic [2:0][15:0] HX_KA = {16'sd32325, -16'sd4789, -16'sd2435};
  localparam logic [2:0][15:0] HX_KB = {16'sd0, -16'sd14852, 16'sd29209};

endpackage

`default_nettype wire

### design/fcpg_channels.sv
// handshake channels of the false-colour palette generator
// depends on fcpg_pkg
`default_nettype none

// index requests
interface fcpg_idx_if;
  logic                         valid;
  logic                         ready;
  logic [fcpg_pkg::IDX_W-1:0]   index;
  modport source (output valid, output index, input ready);
  modport sink   (input valid, input index, output ready);
endinterface

// colour results
interface fcpg_rgb_if;
  logic                         valid;
  logic                         ready;
  logic [fcpg_pkg::CH_W-1:0]    red;
  logic [fcpg_pkg::CH_W-1:0]    green;
  logic [fcpg_pkg::CH_W-1:0]    blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// register writes
interface fcpg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fcpg_pkg::CFG_IDX_W-1:0] index;
  logic [fcpg_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/false_color_palette_generator_unit.sv
// false-colour palette generator: 13 register stages, one request per cycle unless the output is held
// throughput: one index per cycle; the pipeline stalls as a whole on output back-pressure
// stages: entry, 4 divider stages (4 quotient bits each), factor, multiply,
// 4 square-root / sine stages, helix scale, output register
// reset clears valid bits and sets map type rainbow, map size 151
`default_nettype none

`include "false_color_palette_generator_unit_macros.svh"

module false_color_palette_generator_unit (
  input  logic        clk,
  input  logic        rst,
  fcpg_cfg_if.sink    cfg,
  fcpg_idx_if.sink    idx_ch,
  fcpg_rgb_if.source  rgb_ch
);

  localparam int unsigned LAST = 12;

  // configuration registers
  logic [fcpg_pkg::TYPE_W-1:0] map_type;
  logic [fcpg_pkg::N_W-1:0]    map_size;

  // pipeline control
  logic [LAST:0] vld;
  logic          adv;

  // derived sizes
  logic [fcpg_pkg::N_W-1:0]   n_eff, hot_i1, hot_i2, hot_i3;

  // entry
  logic [fcpg_pkg::IDX_W-1:0] idx_sat, hot_k;
  logic [23:0]                ent_num;
  logic [fcpg_pkg::N_W-1:0]   ent_div;
  fcpg_pkg::hot_t             ent_hot;

  // divider stages
  logic [8:0]      dv_rem [0:4];
  logic [15:0]     dv_lo  [0:4];
  logic [15:0]     dv_q   [0:4];
  logic [8:0]      dv_div [0:4];
  fcpg_pkg::hot_t  dv_hot [0:4];
  logic [8:0]      dv_rem_next [1:4];
  logic [15:0]     dv_q_next   [1:4];

  // factor stage
  logic [16:0]     e_y, e_u, e_h;
  logic [15:0]     e_ph, e_pc;
  logic [15:0]     e_fa [0:2];
  logic [15:0]     e_fb [0:2];
  logic [15:0]     e_t_c [0:1];
  logic            e_n_c [0:1];
  fcpg_pkg::rgb_t  e_dir;
  logic [15:0]     fa [0:2];
  logic [15:0]     fb [0:2];
  logic [15:0]     e_t [0:1];
  logic            e_n [0:1];

  // carried values
  logic [15:0]     x_p   [5:10];
  fcpg_pkg::rgb_t  dir_p [5:11];
  logic [13:0]     amp_p [7:10];
  logic [15:0]     m_xx;

  // square root stages
  logic [27:0]     sq_v    [0:4][0:2];
  logic [16:0]     sq_rem  [0:4][0:2];
  logic [13:0]     sq_root [0:4][0:2];
  logic [16:0]     sq_rem_next  [1:4][0:2];
  logic [13:0]     sq_root_next [1:4][0:2];

  // quarter-wave sine stages, slot 0 sine, slot 1 cosine
  logic [15:0]        q6_t [0:1];
  logic [15:0]        q6_t2 [0:1];
  logic               q6_n [0:1];
  logic [15:0]        q7_t [0:1];
  logic [15:0]        q7_t2 [0:1];
  logic [14:0]        q7_p [0:1];
  logic               q7_n [0:1];
  logic [15:0]        q8_t [0:1];
  logic [15:0]        q8_p [0:1];
  logic               q8_n [0:1];
  logic signed [15:0] q9_v [0:1];
  logic signed [15:0] q9_v_next [0:1];

  // helix term and scale
  logic signed [18:0] hx_term [0:2];
  logic signed [18:0] hx_term_next [0:2];
  logic signed [19:0] hx_v [0:2];
  logic signed [19:0] hx_v_next [0:2];
  logic [7:0]         arc_v [0:2];
  logic [7:0]         arc_v_next [0:2];

  // output
  fcpg_pkg::rgb_t     out_rgb, out_rgb_next;

  // register writes, always accepted
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_type <= fcpg_pkg::MAP_RAINBOW;
      map_size <= fcpg_pkg::MAP_SIZE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        fcpg_pkg::REG_MAP_TYPE: map_type <= cfg.data[fcpg_pkg::TYPE_W-1:0];
        fcpg_pkg::REG_MAP_SIZE: map_size <= cfg.data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the output register is held
  assign adv          = !vld[LAST] || rgb_ch.ready;
  assign idx_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], idx_ch.valid};
    end
  end

  // effective size and hot map split points
  always_comb begin
    if (map_size == '0) begin
      n_eff = fcpg_pkg::N_W'(1);
    end else if (map_size > fcpg_pkg::N_W'(fcpg_pkg::MAX_ENTRIES)) begin
      n_eff = fcpg_pkg::N_W'(fcpg_pkg::MAX_ENTRIES);
    end else begin
      n_eff = map_size;
    end
    hot_i1 = fcpg_pkg::N_W'((11'(n_eff) * 11'd3) >> 3);
    hot_i2 = fcpg_pkg::N_W'({hot_i1, 1'b0});
    hot_i3 = n_eff - hot_i2;
  end

  // entry: saturate the index and pick the dividend and divisor
  always_comb begin
    if ({1'b0, idx_ch.index} >= n_eff) begin
      idx_sat = fcpg_pkg::IDX_W'(n_eff - fcpg_pkg::N_W'(1));
    end else begin
      idx_sat = idx_ch.index;
    end
    hot_k   = idx_sat;
    ent_hot = fcpg_pkg::HOT_RED;
    ent_div = n_eff;
    ent_num = {idx_sat, 16'h0000};
    case (map_type)
      fcpg_pkg::MAP_HOT: begin
        if ({1'b0, idx_sat} < hot_i1) begin
          hot_k   = idx_sat;
          ent_div = hot_i1;
          ent_hot = fcpg_pkg::HOT_RED;
        end else if ({1'b0, idx_sat} < hot_i2) begin
          hot_k   = idx_sat - hot_i1[fcpg_pkg::IDX_W-1:0];
          ent_div = hot_i1;
          ent_hot = fcpg_pkg::HOT_GREEN;
        end else begin
          hot_k   = idx_sat - hot_i2[fcpg_pkg::IDX_W-1:0];
          ent_div = hot_i3;
          ent_hot = fcpg_pkg::HOT_BLUE;
        end
        ent_num = 24'(fcpg_pkg::FULL) * 24'(hot_k);
      end
      fcpg_pkg::MAP_GRAY: begin
        ent_num = 24'(fcpg_pkg::FULL) * 24'(idx_sat);
      end
      default: ;
    endcase
  end

  // divider: restoring steps, four quotient bits per stage
  always_comb begin
    logic [9:0] t;
    logic [8:0] r;
    logic [15:0] q;
    for (int s = 1; s <= 4; s++) begin
      r = dv_rem[s-1];
      q = dv_q[s-1];
      for (int j = 0; j < 4; j++) begin
        t = {r, dv_lo[s-1][15 - ((s-1)*4 + j)]};
        if (t >= {1'b0, dv_div[s-1]}) begin
          r = 9'(t - {1'b0, dv_div[s-1]});
          q[15 - ((s-1)*4 + j)] = 1'b1;
        end else begin
          r = t[8:0];
        end
      end
      dv_rem_next[s] = r;
      dv_q_next[s]   = q;
    end
  end

  // factor stage: arc factors, sine phases, direct colours
  always_comb begin
    logic [15:0] x;
    x   = dv_q[4];
    e_y = (map_type == fcpg_pkg::MAP_RAINBOW) ? fcpg_pkg::ONE16 - {1'b0, x} : {1'b0, x};
    if (map_type == fcpg_pkg::MAP_PERIODIC && e_y > fcpg_pkg::TH_HI) begin
      e_u = fcpg_pkg::ONE16 - e_y;
    end else begin
      e_u = e_y;
    end
    // red arc
    if (e_u > fcpg_pkg::TH_LO) begin
      e_fa[0] = '0;
      e_fb[0] = '0;
    end else begin
      e_fa[0] = 16'(fcpg_pkg::TH_LO - e_u);
      e_fb[0] = 16'(e_u + fcpg_pkg::R_OFS);
    end
    // green arc
    if (e_y > fcpg_pkg::G_TOP) begin
      e_fa[1] = '0;
      e_fb[1] = '0;
    end else begin
      e_fa[1] = 16'(fcpg_pkg::G_TOP - e_y);
      e_fb[1] = e_y[15:0];
    end
    // blue arc
    if (e_y < fcpg_pkg::B_LO || e_y > fcpg_pkg::B_TOP) begin
      e_fa[2] = '0;
      e_fb[2] = '0;
    end else begin
      e_fa[2] = 16'(fcpg_pkg::B_TOP - e_y);
      e_fb[2] = 16'(e_y - fcpg_pkg::B_LO);
    end
    // helix phase and quarter-wave arguments
    e_h  = 17'((18'(x) * 18'd3) >> 1);
    e_ph = fcpg_pkg::HX_START - e_h[15:0];
    e_pc = e_ph + fcpg_pkg::HX_QUART;
    e_t_c[0] = e_ph[14] ? 16'h8000 - {1'b0, e_ph[13:0], 1'b0} : {1'b0, e_ph[13:0], 1'b0};
    e_n_c[0] = e_ph[15];
    e_t_c[1] = e_pc[14] ? 16'h8000 - {1'b0, e_pc[13:0], 1'b0} : {1'b0, e_pc[13:0], 1'b0};
    e_n_c[1] = e_pc[15];
    // colours that need no further work
    e_dir = '0;
    case (map_type)
      fcpg_pkg::MAP_HOT: begin
        case (dv_hot[4])
          fcpg_pkg::HOT_RED: begin
            e_dir.red = x;
          end
          fcpg_pkg::HOT_GREEN: begin
            e_dir.red   = fcpg_pkg::FULL;
            e_dir.green = x;
          end
          default: begin
            e_dir.red   = fcpg_pkg::FULL;
            e_dir.green = fcpg_pkg::FULL;
            e_dir.blue  = x;
          end
        endcase
      end
      fcpg_pkg::MAP_COOL, fcpg_pkg::MAP_REDBLUE: begin
        e_dir.red  = 16'((32'(fcpg_pkg::FULL) * 32'(x)) >> 16);
        e_dir.blue = 16'((33'(fcpg_pkg::FULL) * (33'(fcpg_pkg::ONE16) - 33'(x))) >> 16);
        e_dir.green = (map_type == fcpg_pkg::MAP_COOL) ? fcpg_pkg::FULL : 16'h0000;
      end
      fcpg_pkg::MAP_GRAY: begin
        e_dir.red   = x;
        e_dir.green = x;
        e_dir.blue  = x;
      end
      default: ;
    endcase
  end

  // square root: digit pairs, four result bits per stage, two in the last stage
  always_comb begin
    logic [16:0] r;
    logic [16:0] nr;
    logic [16:0] trial;
    logic [13:0] rt;
    for (int s = 1; s <= 4; s++) begin
      for (int c = 0; c < 3; c++) begin
        r  = sq_rem[s-1][c];
        rt = sq_root[s-1][c];
        for (int j = 0; j < 4; j++) begin
          if ((s-1)*4 + j < 14) begin
            nr    = {r[14:0], sq_v[s-1][c][27 - 2*((s-1)*4 + j) -: 2]};
            trial = {1'b0, rt, 2'b01};
            if (nr >= trial) begin
              r  = nr - trial;
              rt = {rt[12:0], 1'b1};
            end else begin
              r  = nr;
              rt = {rt[12:0], 1'b0};
            end
          end
        end
        sq_rem_next[s][c]  = r;
        sq_root_next[s][c] = rt;
      end
    end
  end

  // last sine step with clip and quadrant sign
  always_comb begin
    logic [31:0] pr;
    logic [14:0] mag;
    for (int k = 0; k < 2; k++) begin
      pr  = (32'(q8_p[k]) * 32'(q8_t[k])) >> 15;
      mag = (pr > fcpg_pkg::Q_MAX) ? 15'h7FFF : pr[14:0];
      q9_v_next[k] = q8_n[k] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  // helix term per channel from cosine and sine
  always_comb begin
    logic signed [31:0] acc;
    for (int c = 0; c < 3; c++) begin
      acc = 32'($signed(fcpg_pkg::HX_KA[c])) * 32'(q9_v[1])
          + 32'($signed(fcpg_pkg::HX_KB[c])) * 32'(q9_v[0]);
      hx_term_next[c] = 19'(acc >>> 13);
    end
  end

  // arc scale and clip, helix offset
  always_comb begin
    logic [31:0] pr;
    logic [31:0] sc;
    logic signed [33:0] hp;
    for (int c = 0; c < 3; c++) begin
      if (c == 2) begin
        pr = 32'(sq_root[4][c]) * fcpg_pkg::K_B;
        sc = pr >> fcpg_pkg::SH_B;
      end else begin
        pr = 32'(sq_root[4][c]) * fcpg_pkg::K_RG;
        sc = pr >> fcpg_pkg::SH_RG;
      end
      arc_v_next[c] = (sc > 32'd255) ? 8'hFF : sc[7:0];
      hp = 34'($signed({1'b0, amp_p[10]})) * 34'(hx_term[c]);
      hx_v_next[c] = $signed({4'b0000, x_p[10]}) + 20'(hp >>> 16);
    end
  end

  // output select with helix clip and scale
  always_comb begin
    logic [16:0] cl;
    logic [7:0]  h8 [0:2];
    for (int c = 0; c < 3; c++) begin
      if (hx_v[c][19]) begin
        cl = '0;
      end else if (hx_v[c] > 20'sd65536) begin
        cl = fcpg_pkg::ONE16;
      end else begin
        cl = hx_v[c][16:0];
      end
      h8[c] = 8'((25'(cl) * 25'd255) >> 16);
    end
    case (map_type)
      fcpg_pkg::MAP_RAINBOW, fcpg_pkg::MAP_PERIODIC: begin
        out_rgb_next = {arc_v[0], 8'h00, arc_v[1], 8'h00, arc_v[2], 8'h00};
      end
      fcpg_pkg::MAP_HELIX: begin
        out_rgb_next = {h8[0], 8'h00, h8[1], 8'h00, h8[2], 8'h00};
      end
      default: begin
        out_rgb_next = dir_p[11];
      end
    endcase
  end

  // pipeline data registers
  always_ff @(posedge clk) begin
    if (adv) begin
      // entry
      dv_rem[0] <= {1'b0, ent_num[23:16]};
      dv_lo[0]  <= ent_num[15:0];
      dv_q[0]   <= '0;
      dv_div[0] <= ent_div;
      dv_hot[0] <= ent_hot;
      // divider
      for (int s = 1; s <= 4; s++) begin
        dv_rem[s] <= dv_rem_next[s];
        dv_q[s]   <= dv_q_next[s];
        dv_lo[s]  <= dv_lo[s-1];
        dv_div[s] <= dv_div[s-1];
        dv_hot[s] <= dv_hot[s-1];
      end
      // factor stage
      for (int c = 0; c < 3; c++) begin
        fa[c] <= e_fa[c];
        fb[c] <= e_fb[c];
      end
      for (int k = 0; k < 2; k++) begin
        e_t[k] <= e_t_c[k];
        e_n[k] <= e_n_c[k];
      end
      x_p[5]   <= dv_q[4];
      dir_p[5] <= e_dir;
      // multiply stage
      for (int c = 0; c < 3; c++) begin
        sq_v[0][c]    <= 28'((32'(fa[c]) * 32'(fb[c])) >> 2);
        sq_rem[0][c]  <= '0;
        sq_root[0][c] <= '0;
      end
      for (int k = 0; k < 2; k++) begin
        q6_t[k]  <= e_t[k];
        q6_t2[k] <= 16'((32'(e_t[k]) * 32'(e_t[k])) >> 15);
        q6_n[k]  <= e_n[k];
      end
      m_xx <= 16'((33'(x_p[5]) * (33'(fcpg_pkg::ONE16) - 33'(x_p[5]))) >> 16);
      // square root stages
      for (int s = 1; s <= 4; s++) begin
        for (int c = 0; c < 3; c++) begin
          sq_v[s][c]    <= sq_v[s-1][c];
          sq_rem[s][c]  <= sq_rem_next[s][c];
          sq_root[s][c] <= sq_root_next[s][c];
        end
      end
      // sine polynomial stages
      for (int k = 0; k < 2; k++) begin
        q7_t[k]  <= q6_t[k];
        q7_t2[k] <= q6_t2[k];
        q7_n[k]  <= q6_n[k];
        q7_p[k]  <= 15'(fcpg_pkg::Q_C2 - 16'((fcpg_pkg::Q_C1 * 32'(q6_t2[k])) >> 15));
        q8_t[k]  <= q7_t[k];
        q8_n[k]  <= q7_n[k];
        q8_p[k]  <= fcpg_pkg::Q_C3 - 16'((32'(q7_p[k]) * 32'(q7_t2[k])) >> 15);
        q9_v[k]  <= q9_v_next[k];
      end
      amp_p[7] <= 14'((32'(m_xx) * fcpg_pkg::HX_AMP) >> 16);
      for (int s = 8; s <= 10; s++) begin
        amp_p[s] <= amp_p[s-1];
      end
      for (int s = 6; s <= 10; s++) begin
        x_p[s] <= x_p[s-1];
      end
      for (int s = 6; s <= 11; s++) begin
        dir_p[s] <= dir_p[s-1];
      end
      // helix and arc finish
      for (int c = 0; c < 3; c++) begin
        hx_term[c] <= hx_term_next[c];
        hx_v[c]    <= hx_v_next[c];
        arc_v[c]   <= arc_v_next[c];
      end
      out_rgb <= out_rgb_next;
    end
  end

  assign rgb_ch.valid = vld[LAST];
  assign rgb_ch.red   = out_rgb.red;
  assign rgb_ch.green = out_rgb.green;
  assign rgb_ch.blue  = out_rgb.blue;

  // checks
  `FCPG_ASSERT_HOLDS(a_div_rem, vld[4], dv_rem[4] < dv_div[4])
  `FCPG_ASSERT_HOLDS(a_ramp_full, vld[4] && (map_type == fcpg_pkg::MAP_HOT || map_type == fcpg_pkg::MAP_GRAY), dv_q[4] <= fcpg_pkg::FULL)
  `FCPG_ASSERT_HOLDS(a_sqrt_floor, vld[10], 28'(32'(sq_root[4][0]) * 32'(sq_root[4][0])) <= sq_v[4][0])
  `FCPG_ASSERT_NEXT(a_fill_out, vld[LAST-1] && !vld[LAST], vld[LAST])

endmodule

`default_nettype wire

### test/false_color_palette_generator_unit_tb.sv
// testbench of the false-colour palette generator: directed table, then random requests
// predicts or looks up each colour, checks all results; depends on fcpg_pkg, fcpg_channels
`default_nettype none

module false_color_palette_generator_unit_tb;
  import fcpg_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [2:0]  mtype;
    logic [8:0]  msize;
    logic [7:0]  index;
    bit          typed;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fcpg_cfg_if cfg_bus ();
  fcpg_idx_if idx_bus ();
  fcpg_rgb_if rgb_bus ();

  false_color_palette_generator_unit uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus.sink),
    .idx_ch (idx_bus.sink),
    .rgb_ch (rgb_bus.source)
  );

  rgb_t        colour_q[$];
  logic [2:0]  cur_type = MAP_RAINBOW;
  logic [8:0]  cur_size = MAP_SIZE_RST;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          failed = 1'b0;
  int          quiet_cycles = 0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------- colour prediction ----------------

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned arc_level(longint unsigned prod, longint unsigned k,
                                                int sh);
    longint unsigned v;
    v = (root_floor(prod >> 2) * k) >> sh;
    return (v > 255) ? 255 : v;
  endfunction

  function automatic longint unsigned red_arc(longint unsigned y, bit periodic);
    longint unsigned u;
    u = y;
    if (periodic && y > TH_HI) u = ONE16 - y;
    if (u > TH_LO) return 0;
    return arc_level((TH_LO - u) * (u + R_OFS), K_RG, SH_RG);
  endfunction

  function automatic longint unsigned green_arc(longint unsigned y);
    if (y > TH_HI) return 0;
    return arc_level((G_TOP - y) * y, K_RG, SH_RG);
  endfunction

  function automatic longint unsigned blue_arc(longint unsigned y);
    if (y < B_LO || y > B_TOP) return 0;
    return arc_level((B_TOP - y) * (y - B_LO), K_B, SH_B);
  endfunction

  // sin(pi/2 * t), t and result in Q15
  function automatic longint quarter_wave(longint unsigned t);
    longint unsigned t2, p;
    t2 = (t * t) >> 15;
    p = (2463 * t2) >> 15;
    p = 21167 - p;
    p = (p * t2) >> 15;
    p = 51472 - p;
    p = (p * t) >> 15;
    if (p > 32767) p = 32767;
    return longint'(p);
  endfunction

  // sine of a phase in Q0.16 turns
  function automatic longint turn_sine(longint unsigned ph);
    longint unsigned q, t;
    longint v;
    q = (ph >> 14) & 3;
    t = (ph & 16'h3FFF) << 1;
    v = q[0] ? quarter_wave(32768 - t) : quarter_wave(t);
    return q[1] ? -v : v;
  endfunction

  function automatic longint unsigned helix_level(longint unsigned x, longint amp, longint c,
                                                  longint s, longint ka, longint kb);
    longint term, v;
    term = (ka * c + kb * s) >>> 13;
    v = longint'(x) + ((amp * term) >>> 16);
    if (v < 0) v = 0;
    if (v > 65536) v = 65536;
    return 256 * ((longint'(v) * 255) >> 16);
  endfunction

  function automatic rgb_t colour_of(logic [2:0] mtype, logic [8:0] msize, logic [7:0] index);
    longint unsigned n, i, x, y, r, g, b, i1, i2, i3, ph, xx;
    longint s, c, amp;
    rgb_t res;
    n = msize;
    i = index;
    r = 0;
    g = 0;
    b = 0;
    if (n == 0) n = 1;
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    if (i >= n) i = n - 1;
    x = (i << 16) / n;
    case (mtype)
      MAP_RAINBOW: begin
        y = 65536 - x;
        r = red_arc(y, 1'b0) << 8;
        g = green_arc(y) << 8;
        b = blue_arc(y) << 8;
      end
      MAP_PERIODIC: begin
        r = red_arc(x, 1'b1) << 8;
        g = green_arc(x) << 8;
        b = blue_arc(x) << 8;
      end
      MAP_HOT: begin
        i1 = (3 * n) >> 3;
        i2 = 2 * i1;
        i3 = n - i2;
        if (i < i1) begin
          r = (FULL * i) / i1;
        end else if (i < i2) begin
          r = FULL;
          g = (FULL * (i - i1)) / i1;
        end else begin
          r = FULL;
          g = FULL;
          b = (FULL * (i - i2)) / i3;
        end
      end
      MAP_COOL, MAP_REDBLUE: begin
        r = (FULL * x) >> 16;
        b = (FULL * (65536 - x)) >> 16;
        g = (mtype == MAP_COOL) ? FULL : 0;
      end
      MAP_GRAY: begin
        r = (i * FULL) / n;
        g = r;
        b = r;
      end
      MAP_HELIX: begin
        ph = (HX_START + 131072 - ((3 * x) >> 1)) & 16'hFFFF;
        s = turn_sine(ph);
        c = turn_sine((ph + 16384) & 16'hFFFF);
        xx = (x * (65536 - x)) >> 16;
        amp = longint'((xx * HX_AMP) >> 16);
        r = helix_level(x, amp, c, s, -2435, 29209);
        g = helix_level(x, amp, c, s, -4789, -14852);
        b = helix_level(x, amp, c, s, 32325, 0);
      end
      default: ;
    endcase
    res.red = r[15:0];
    res.green = g[15:0];
    res.blue = b[15:0];
    return res;
  endfunction

  // ---------------- drivers ----------------

  initial begin
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_MAP_TYPE;
    cfg_bus.data = '0;
    idx_bus.valid = 1'b0;
    idx_bus.index = '0;
    rgb_bus.ready = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off on demand
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rgb_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        rgb_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // leaves valid high so that writes can follow back to back
  task automatic write_reg(cfg_reg_t which, logic [8:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= which;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
  endtask

  // reconfigure only once the pipeline is empty
  task automatic set_map(logic [2:0] mtype, logic [8:0] msize, bit force_all);
    idx_bus.valid <= 1'b0;
    while (colour_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (force_all || mtype != cur_type) begin
      write_reg(REG_MAP_TYPE, {6'd0, mtype});
      cur_type = mtype;
    end
    if (force_all || msize != cur_size) begin
      write_reg(REG_MAP_SIZE, msize);
      cur_size = msize;
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_index(logic [7:0] index, bit typed, rgb_t typed_colour);
    while ($urandom_range(99) < send_idle_pct) begin
      idx_bus.valid <= 1'b0;
      @(negedge clk);
    end
    idx_bus.valid <= 1'b1;
    idx_bus.index <= index;
    do @(posedge clk); while (!idx_bus.ready);
    colour_q.push_back(typed ? typed_colour : colour_of(cur_type, cur_size, index));
    @(negedge clk);
  endtask

  function automatic logic [8:0] pick_size();
    int k;
    k = $urandom_range(19);
    if (k == 0) return 9'd0;
    if (k == 1) return 9'd1;
    if (k == 2) return 9'd256;
    if (k == 3) return 9'($urandom_range(511, 257));
    if (k < 8) return 9'($urandom_range(16, 2));
    return 9'($urandom_range(255, 2));
  endfunction

  table_row_t rows[21];

  initial begin
    rgb_t c;
    int phase, set_no, k;
    rows = '{
      '{MAP_RAINBOW,  9'd151, 8'd0,   1'b0, 16'd0, 16'd0, 16'd0},
      '{MAP_RAINBOW,  9'd151, 8'd255, 1'b0, 16'd0, 16'd0, 16'd0},
      '{MAP_PERIODIC, 9'd151, 8'd0,   1'b0, 16'd0, 16'd0, 16'd0},
      '{MAP_PERIODIC, 9'd151, 8'd100, 1'b0, 16'd0, 16'd0, 16'd0},
      '{MAP_HOT,      9'd8,   8'd7,   1'b1, FULL, FULL, 16'd32640},
      '{MAP_HOT,      9'd8,   8'd0,   1'b1, 16'd0, 16'd0, 16'd0},
      '{MAP_HOT,      9'd1,   8'd0,   1'b0, 16'd0, 16'd0, 16'd0},
      '{MAP_COOL,     9'd256, 8'd0,   1'b1, 16'd0, FULL, FULL},
      '{MAP_REDBLUE,  9'd256, 8'd0,   1'b1, 16'd0, 16'd0, FULL},
      '{MAP_REDBLUE,  9'd256, 8'd255, 1'b0, 16'd0, 16'd0, 16'd0},
      '{MAP_GRAY,     9'd256, 8'd255, 1'b1, 16'd65025, 16'd65025, 16'd65025},
      '{MAP_GRAY,     9'd0,   8'd200, 1'b1, 16'd0, 16'd0, 16'd0},
      '{MAP_GRAY,     9'd511, 8'd255, 1'b1, 16'd65025, 16'd65025, 16'd65025},
      '{MAP_HELIX,    9'd256, 8'd0,   1'b0, 16'd0, 16'd0, 16'd0},
      '{MAP_HELIX,    9'd256, 8'd128, 1'b0, 16'd0, 16'd0, 16'd0},
      '{MAP_HELIX,    9'd256, 8'd255, 1'b0, 16'd0, 16'd0, 16'd0},
      '{3'd7,         9'd100, 8'd50,  1'b1, 16'd0, 16'd0, 16'd0},
      '{MAP_RAINBOW,  9'd2,   8'd1,   1'b0, 16'd0, 16'd0, 16'd0},
      '{MAP_PERIODIC, 9'd256, 8'd255, 1'b0, 16'd0, 16'd0, 16'd0},
      '{MAP_HOT,      9'd256, 8'd255, 1'b0, 16'd0, 16'd0, 16'd0},
      '{MAP_COOL,     9'd1,   8'd255, 1'b0, 16'd0, 16'd0, 16'd0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (rows[row]) begin
      set_map(rows[row].mtype, rows[row].msize, row == 0);
      c.red = rows[row].red;
      c.green = rows[row].green;
      c.blue = rows[row].blue;
      send_index(rows[row].index, rows[row].typed, c);
    end

    // random part: four phases of sender idling and receiver stalls, several map settings in each
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 64 : 6) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 64 : 6) : 0;
      for (set_no = 0; set_no < 6; set_no++) begin
        set_map(3'($urandom_range(7)), pick_size(), 1'b0);
        for (k = 0; k < 25; k++) begin
          if (phase == 0 && set_no == 1 && k == 3) hold_req = 1'b1;
          send_index(8'($urandom_range(255)), 1'b0, c);
        end
      end
    end
    idx_bus.valid <= 1'b0;

    while (colour_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------- checking ----------------

  always @(posedge clk) begin
    rgb_t want;
    if (!rst && rgb_bus.valid && rgb_bus.ready) begin
      if (colour_q.size() == 0) begin
        $error("colour result with no request outstanding");
        failed = 1'b1;
      end else begin
        want = colour_q.pop_front();
        if (rgb_bus.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, rgb_bus.red);
          failed = 1'b1;
        end
        if (rgb_bus.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, rgb_bus.green);
          failed = 1'b1;
        end
        if (rgb_bus.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, rgb_bus.blue);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (rst || (rgb_bus.valid && rgb_bus.ready) || (idx_bus.valid && idx_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire

### false_color_palette_generator_unit.f
+incdir+design
design/fcpg_pkg.sv
design/fcpg_channels.sv
design/false_color_palette_generator_unit.sv
test/false_color_palette_generator_unit_tb.sv
